// ----- src/fault_edge_priority_counters_defines.svh -----
// assertion macros for the fault edge priority counters
`ifndef FAULT_EDGE_PRIORITY_COUNTERS_DEFINES_SVH
`define FAULT_EDGE_PRIORITY_COUNTERS_DEFINES_SVH

// same-cycle implication
`define FEPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fepc check failed");

// next-cycle implication
`define FEPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fepc check failed");

`endif

// ----- src/fepc_pkg.sv -----
// types, constants and the bit-to-slot table of the fault edge priority counters
package fepc_pkg;

  localparam int unsigned VecW   = 24;
  localparam int unsigned CountW = 4;
  localparam int unsigned IdW    = 5;

  localparam logic [VecW-1:0]   VecMask    = 24'h7F7FFF;
  localparam int unsigned       ForceBit   = 20;
  localparam logic [CountW-1:0] LimitReset = 4'd10;
  localparam logic [7:0]        NoSlot     = 8'hFF;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_FETCH    = 1'b1
  } command_t;

  typedef struct packed {
    logic [IdW-1:0] fault_id;
    logic           fault_found;
    logic           all_clear;
  } result_t;

  localparam logic [7:0] SlotOfBit [VecW] = '{
    8'd3,  8'd5,  8'd4,  8'd6,  8'd18, 8'd17, 8'd16, 8'd15,
    8'd2,  8'd7,  8'd10, 8'd20, 8'd19, 8'd9,  8'd8,  NoSlot,
    8'd14, 8'd13, 8'd12, 8'd11, 8'd1,  8'd21, 8'd22, NoSlot
  };

endpackage

// ----- src/fepc_if.sv -----
// valid/ready channels for request and result words
interface fepc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [fepc_pkg::VecW-1:0]   diag_code;

  modport source (output valid, output command, output diag_code, input ready);
  modport sink (input valid, input command, input diag_code, output ready);
endinterface

interface fepc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fepc_pkg::IdW-1:0]    fault_id;
  logic                        fault_found;
  logic                        all_clear;

  modport source (output valid, output fault_id, output fault_found, output all_clear,
                  input ready);
  modport sink (input valid, input fault_id, input fault_found, input all_clear,
                output ready);
endinterface

// ----- src/fepc_update.sv -----
// next counter state, stored vector and result for one word
module fepc_update #(
  parameter int unsigned SLOT_COUNT = 24
) (
  input  logic [SLOT_COUNT-1:0][fepc_pkg::CountW-1:0] counts,
  input  logic [fepc_pkg::VecW-1:0]                   prev,
  input  logic [fepc_pkg::CountW-1:0]                 limit,
  input  logic                                        command,
  input  logic [fepc_pkg::VecW-1:0]                   diag_code,
  output logic [SLOT_COUNT-1:0][fepc_pkg::CountW-1:0] counts_next,
  output logic [fepc_pkg::VecW-1:0]                   prev_next,
  output fepc_pkg::result_t                           result
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);

  logic [fepc_pkg::VecW-1:0] vec;
  logic [fepc_pkg::VecW-1:0] rising;
  logic [SLOT_COUNT-1:0]     hit;
  logic [SLOT_COUNT-1:0]     nonzero;
  logic [SLOT_COUNT-1:0]     first;
  logic                      seen;

  assign vec    = diag_code & fepc_pkg::VecMask;
  assign rising = vec & ~prev;

  // rising bits mapped to slots
  always_comb begin
    hit = '0;
    for (int unsigned b = 0; b < fepc_pkg::VecW; b++) begin
      if (rising[b] && (fepc_pkg::SlotOfBit[b] < 8'(SLOT_COUNT))) begin
        hit[fepc_pkg::SlotOfBit[b][IdxW-1:0]] = 1'b1;
      end
    end
  end

  // lowest nonzero slot
  always_comb begin
    seen  = 1'b0;
    first = '0;
    for (int unsigned s = 0; s < SLOT_COUNT; s++) begin
      nonzero[s] = (counts[s] != '0);
      first[s]   = nonzero[s] && !seen;
      seen       = seen || nonzero[s];
    end
  end

  always_comb begin
    counts_next        = counts;
    prev_next          = prev;
    result.fault_id    = '0;
    result.fault_found = 1'b0;
    unique case (fepc_pkg::command_t'(command))
      fepc_pkg::CMD_REGISTER: begin
        prev_next = vec;
        for (int unsigned s = 0; s < SLOT_COUNT; s++) begin
          if (hit[s] && (counts[s] < limit)) begin
            counts_next[s] = counts[s] + 1'b1;
          end
        end
        counts_next[0] = '0;
        if (vec[fepc_pkg::ForceBit]) begin
          counts_next[1] = fepc_pkg::CountW'(1);
        end
      end
      fepc_pkg::CMD_FETCH: begin
        for (int unsigned s = 0; s < SLOT_COUNT; s++) begin
          if (first[s]) begin
            counts_next[s]  = counts[s] - 1'b1;
            result.fault_id = fepc_pkg::IdW'(s);
          end
        end
        result.fault_found = seen;
      end
      default: begin
        prev_next = prev;
      end
    endcase
    result.all_clear = (prev_next == '0);
  end

endmodule

// ----- src/fault_edge_priority_counters.sv -----
// top level of the fault edge priority counters
//
// request carries a command and a 24-bit diagnostic code; result carries
// fault_id, fault_found and all_clear, one result word per request word.
// a register word masks the code, counts each newly risen bit in its slot
// (saturating at count_limit), clears slot 0 and pins slot 1 to one when
// bit 20 is set; a fetch word returns and decrements the lowest busy slot.
// count_limit is loaded through cfg_wr_en / cfg_wr_data; the user must load it
// only while idle, as the block does not enforce this. a request word is held in
// an input register, processed in a single pass of logic as it moves into the
// result register, and shows up on result from there. one word per cycle is
// sustained while result.ready stays high.
// the result register holds while result.ready is low; the input register
// keeps taking words until it is full, then request.ready drops.
// reset clears the stored vector, all counters, both valid flags and sets
// count_limit to 10.
module fault_edge_priority_counters #(
  parameter int unsigned SLOT_COUNT = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  fepc_req_if.sink                     request,
  fepc_rsp_if.source                   result,
  input  logic                         cfg_wr_en,
  input  logic [fepc_pkg::CountW-1:0]  cfg_wr_data
);

  `include "fault_edge_priority_counters_defines.svh"

  logic [SLOT_COUNT-1:0][fepc_pkg::CountW-1:0] counts;
  logic [SLOT_COUNT-1:0][fepc_pkg::CountW-1:0] counts_next;
  logic [fepc_pkg::VecW-1:0]                   prev;
  logic [fepc_pkg::VecW-1:0]                   prev_next;
  logic [fepc_pkg::CountW-1:0]                 limit;

  logic                      held_valid;
  logic                      held_command;
  logic [fepc_pkg::VecW-1:0] held_diag;
  logic                      out_valid;
  fepc_pkg::result_t         out_word;
  fepc_pkg::result_t         update_word;
  logic                      advance;
  logic                      force_hit;

  assign advance       = held_valid && (!out_valid || result.ready);
  assign request.ready = !held_valid || advance;

  fepc_update #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_update (
    .counts      (counts),
    .prev        (prev),
    .limit       (limit),
    .command     (held_command),
    .diag_code   (held_diag),
    .counts_next (counts_next),
    .prev_next   (prev_next),
    .result      (update_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= fepc_pkg::LimitReset;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (request.ready) begin
      held_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      held_command <= request.command;
      held_diag    <= request.diag_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
      prev   <= '0;
    end else if (advance) begin
      counts <= counts_next;
      prev   <= prev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= update_word;
    end
  end

  assign result.valid       = out_valid;
  assign result.fault_id    = out_word.fault_id;
  assign result.fault_found = out_word.fault_found;
  assign result.all_clear   = out_word.all_clear;

  assign force_hit = advance && (held_command == fepc_pkg::CMD_REGISTER)
                     && held_diag[fepc_pkg::ForceBit];

  `FEPC_ASSERT_NOW(a_slot0_zero, clk, rst, 1'b1, counts[0] == '0)
  `FEPC_ASSERT_NEXT(a_force_slot1, clk, rst, force_hit, counts[1] == fepc_pkg::CountW'(1))
  `FEPC_ASSERT_NOW(a_found_nonzero, clk, rst, out_valid && out_word.fault_found, out_word.fault_id != '0)
  `FEPC_ASSERT_NEXT(a_clear_match, clk, rst, advance, out_word.all_clear == (prev == '0))

endmodule
